FILE: rtl/prde_pkg.sv
// prde_pkg: shared types and codes for the pattern rectangle draw engine
// holds the port word structs, the internal command word and the register codes
// no dependencies
package prde_pkg;

	localparam int PIX_W = 24;
	localparam int PAT_W = 64;
	localparam int CFG_W = 64;
	localparam int COORD_W = 16;

	localparam logic [PIX_W-1:0] WHITE_PIX = 24'hFFFFFF;

	// request codes
	localparam logic [2:0] REQ_FRAME  = 3'd0;
	localparam logic [2:0] REQ_PAINT  = 3'd1;
	localparam logic [2:0] REQ_ERASE  = 3'd2;
	localparam logic [2:0] REQ_INVERT = 3'd3;
	localparam logic [2:0] REQ_FILL   = 3'd4;
	localparam logic [2:0] REQ_READ   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_FORE  = 3'd0;
	localparam logic [2:0] CFG_BACK  = 3'd1;
	localparam logic [2:0] CFG_PEN   = 3'd2;
	localparam logic [2:0] CFG_ERASE = 3'd3;
	localparam logic [2:0] CFG_PORT  = 3'd4;

	typedef struct packed {
		logic [2:0]                 req_type;
		logic signed [COORD_W-1:0]  rect_top;
		logic signed [COORD_W-1:0]  rect_left;
		logic signed [COORD_W-1:0]  rect_bottom;
		logic signed [COORD_W-1:0]  rect_right;
		logic [PAT_W-1:0]           fill_pattern;
	} in_word_t;

	typedef struct packed {
		logic             status;
		logic [PIX_W-1:0] read_value;
	} out_word_t;

	typedef enum logic [1:0] {
		CMD_RESP,
		CMD_READ,
		CMD_DRAW
	} cmd_kind_t;

	typedef enum logic [1:0] {
		OP_FRAME,
		OP_PAT,
		OP_INV
	} draw_op_t;

	// classified command, coordinates already clipped and non-negative
	typedef struct packed {
		cmd_kind_t          kind;
		draw_op_t           op;
		logic               status;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] right;
		logic [PAT_W-1:0]   pattern;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

FILE: rtl/pattern_rect_draw_engine.sv
// pattern_rect_draw_engine: top level of the rectangle draw engine
// depends on prde_pkg, prde_fifo, prde_front and prde_back
//
// usage
// - commands enter as a queue: a word is taken when push is high and full is low
// - results leave as a queue: the oldest result sits on result while empty is low,
//   and is taken when pop is high and empty is low; every command gives one result
// - registers are written through cfg_we / cfg_index / cfg_data, no read-back; the
//   user must do so only while no command is in flight, unchecked by the block
// draw and read flow
// - a draw command scans the clipped rectangle in the back end, row by row, at
//   one pixel per cycle through the single write port of the frame store
// - a pixel read passes ST_READ and ST_RWAIT; a non-drawing command goes to ST_DONE
// - invert reads and rewrites each pixel, pipelined so it still runs one pixel a cycle
// reset
// - after arst_n rises the frame store is swept to zero, FB_WIDTH * FB_HEIGHT words
//   in all; full stays high for that whole pass
// stalls
// - the command queue and the result queue each hold two words, so the front keeps
//   taking commands while the back works and while a result waits to be popped
module pattern_rect_draw_engine #(
	parameter int FB_WIDTH  = 64,
	parameter int FB_HEIGHT = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  prde_pkg::in_word_t          cmd,
	output logic                        full,
	input  logic                        pop,
	output prde_pkg::out_word_t         result,
	output logic                        empty,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [prde_pkg::CFG_W-1:0]  cfg_data
);

	localparam int CMD_W = $bits(prde_pkg::cmd_t);
	localparam int RES_W = $bits(prde_pkg::out_word_t);

	// configuration registers
	logic [prde_pkg::PIX_W-1:0] fore_q;
	logic [prde_pkg::PIX_W-1:0] back_q;
	logic [prde_pkg::PAT_W-1:0] pen_q;
	logic [prde_pkg::PAT_W-1:0] erase_q;
	logic                       port_en_q;

	// front to command queue
	logic                 q_push, q_full, q_pop, q_empty;
	prde_pkg::cmd_t       q_wdata, q_rdata;
	logic [CMD_W-1:0]     q_rbits;

	// back to result queue
	logic                 res_push, res_full;
	prde_pkg::out_word_t  res_wdata;
	logic [RES_W-1:0]     res_rbits;

	prde_pkg::back_stat_t back_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q    <= '0;
			back_q    <= prde_pkg::WHITE_PIX;
			pen_q     <= '1;
			erase_q   <= '0;
			port_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prde_pkg::CFG_FORE:  fore_q    <= cfg_data[prde_pkg::PIX_W-1:0];
				prde_pkg::CFG_BACK:  back_q    <= cfg_data[prde_pkg::PIX_W-1:0];
				prde_pkg::CFG_PEN:   pen_q     <= cfg_data;
				prde_pkg::CFG_ERASE: erase_q   <= cfg_data;
				prde_pkg::CFG_PORT:  port_en_q <= cfg_data[0];
				default:             ; // unused index, write dropped
			endcase
		end
	end

	// front end: clipping and classification, pattern chosen here
	prde_front #(
		.FB_WIDTH  (FB_WIDTH),
		.FB_HEIGHT (FB_HEIGHT)
	) u_front (
		.cmd       (cmd),
		.push      (push),
		.full      (full),
		.port_en   (port_en_q),
		.pen_pat   (pen_q),
		.erase_pat (erase_q),
		.back_stat (back_stat),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// command queue between front and back
	prde_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rbits),
		.empty   (q_empty)
	);

	assign q_rdata = prde_pkg::cmd_t'(q_rbits);

	// back end: pixel scan over the frame store
	prde_back #(
		.FB_WIDTH  (FB_WIDTH),
		.FB_HEIGHT (FB_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.fore_pix (fore_q),
		.back_pix (back_q),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_wdata),
		.stat     (back_stat)
	);

	// result queue, decouples the back end from the consumer
	prde_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wdata),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_rbits),
		.empty   (empty)
	);

	assign result = prde_pkg::out_word_t'(res_rbits);

	// no command taken while the frame store is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.clearing |-> full)
		else $error("command accepted during clear pass");

	// back end only pushes a result when the result queue has room
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// back end only pops a command that is there
	a_cmd_there: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from empty queue");

	// the back end never overlaps two commands: a pop moves it out of ST_IDLE
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back end overlapped two commands");

endmodule

FILE: rtl/prde_fifo.sv
// prde_fifo: small register fifo for fixed-width words
// used for the command queue and the result queue; no package dependency
module prde_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/prde_front.sv
// prde_front: accepts commands, clips rectangles and classifies them
// depends on prde_pkg; feeds the command queue
module prde_front #(
	parameter int FB_WIDTH  = 64,
	parameter int FB_HEIGHT = 64
) (
	input  prde_pkg::in_word_t          cmd,
	input  logic                        push,
	output logic                        full,
	input  logic                        port_en,
	input  logic [prde_pkg::PAT_W-1:0]  pen_pat,
	input  logic [prde_pkg::PAT_W-1:0]  erase_pat,
	input  prde_pkg::back_stat_t        back_stat,
	input  logic                        q_full,
	output logic                        q_push,
	output prde_pkg::cmd_t              q_data
);

	localparam logic signed [16:0] H_S = 17'(FB_HEIGHT);
	localparam logic signed [16:0] W_S = 17'(FB_WIDTH);

	logic signed [16:0] t_s, l_s, b_s, r_s;
	logic signed [16:0] top_c, left_c, bot_c, right_c;
	logic               rect_empty;
	logic               read_in;

	assign full   = q_full || back_stat.clearing;
	assign q_push = push && !full;

	always_comb begin
		t_s = {cmd.rect_top[15], cmd.rect_top};
		l_s = {cmd.rect_left[15], cmd.rect_left};
		b_s = {cmd.rect_bottom[15], cmd.rect_bottom};
		r_s = {cmd.rect_right[15], cmd.rect_right};

		top_c   = t_s[16] ? 17'sd0 : t_s;
		left_c  = l_s[16] ? 17'sd0 : l_s;
		bot_c   = (b_s > H_S) ? H_S : b_s;
		right_c = (r_s > W_S) ? W_S : r_s;

		rect_empty = (bot_c <= top_c) || (right_c <= left_c);
		read_in    = !t_s[16] && (t_s < H_S) && !l_s[16] && (l_s < W_S);

		q_data         = '0;
		q_data.kind    = prde_pkg::CMD_RESP;
		q_data.op      = prde_pkg::OP_PAT;
		q_data.pattern = cmd.fill_pattern;

		priority if (!port_en) begin
			q_data.status = 1'b1;
		end else if (cmd.req_type == prde_pkg::REQ_READ) begin
			if (read_in) begin
				q_data.kind = prde_pkg::CMD_READ;
				q_data.top  = t_s[15:0];
				q_data.left = l_s[15:0];
			end
		end else if (cmd.req_type > prde_pkg::REQ_READ) begin
			q_data.kind = prde_pkg::CMD_RESP;
		end else if (!rect_empty) begin
			q_data.kind   = prde_pkg::CMD_DRAW;
			q_data.top    = top_c[15:0];
			q_data.left   = left_c[15:0];
			q_data.bottom = bot_c[15:0];
			q_data.right  = right_c[15:0];
			unique case (cmd.req_type)
				prde_pkg::REQ_FRAME:  q_data.op = prde_pkg::OP_FRAME;
				prde_pkg::REQ_INVERT: q_data.op = prde_pkg::OP_INV;
				prde_pkg::REQ_PAINT:  q_data.pattern = pen_pat;
				prde_pkg::REQ_ERASE:  q_data.pattern = erase_pat;
				default:              q_data.op = prde_pkg::OP_PAT;
			endcase
		end
	end

endmodule

FILE: rtl/prde_back.sv
// prde_back: executes classified commands against the frame store memory
// depends on prde_pkg; pops the command queue, pushes the result queue
module prde_back #(
	parameter int FB_WIDTH  = 64,
	parameter int FB_HEIGHT = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  prde_pkg::cmd_t              q_data,
	output logic                        q_pop,
	input  logic [prde_pkg::PIX_W-1:0]  fore_pix,
	input  logic [prde_pkg::PIX_W-1:0]  back_pix,
	input  logic                        res_full,
	output logic                        res_push,
	output prde_pkg::out_word_t         res_data,
	output prde_pkg::back_stat_t        stat
);

	localparam int FB_DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int AW = $clog2(FB_DEPTH);
	localparam int XW = $clog2(FB_WIDTH + 1);
	localparam int YW = $clog2(FB_HEIGHT + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(FB_DEPTH - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(FB_WIDTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_READ,
		ST_RWAIT,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              clr_q;
	prde_pkg::cmd_t             cmd_q;
	logic [YW-1:0]              v_q;
	logic [XW-1:0]              h_q;
	logic [AW-1:0]              base_q;
	prde_pkg::out_word_t        res_q;

	logic                       wr_s1;
	logic                       inv_s1;
	logic [AW-1:0]              addr_s1;
	logic [prde_pkg::PIX_W-1:0] data_s1;

	logic [prde_pkg::PIX_W-1:0] mem [FB_DEPTH];
	logic [prde_pkg::PIX_W-1:0] rd_data_q;
	logic                       mem_we;
	logic [AW-1:0]              mem_addr;
	logic [prde_pkg::PIX_W-1:0] mem_wdata;
	logic [AW-1:0]              rd_addr;

	logic [YW-1:0]              v_next;
	logic [XW-1:0]              h_next;
	logic                       v_last, h_last;
	logic                       on_edge;
	logic                       pat_bit;

	assign stat.clearing = (state_q == ST_CLEAR);
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign res_push = (state_q == ST_DONE) && !res_full;
	assign res_data = res_q;

	always_comb begin
		v_next  = v_q + 1'b1;
		h_next  = h_q + 1'b1;
		v_last  = (v_next == cmd_q.bottom[YW-1:0]);
		h_last  = (h_next == cmd_q.right[XW-1:0]);
		on_edge = (v_q == cmd_q.top[YW-1:0]) || v_last ||
		          (h_q == cmd_q.left[XW-1:0]) || h_last;
		// row v&7 picks the byte, bit 7 of the byte is the leftmost column
		pat_bit = cmd_q.pattern[{v_q[2:0], ~h_q[2:0]}];
		rd_addr = base_q + AW'(h_q);

		mem_we    = stat.clearing || wr_s1;
		mem_addr  = stat.clearing ? clr_q : addr_s1;
		if (stat.clearing) begin
			mem_wdata = '0;
		end else if (inv_s1) begin
			mem_wdata = rd_data_q ^ prde_pkg::WHITE_PIX;
		end else begin
			mem_wdata = data_s1;
		end
	end

	// frame store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wr_s1   <= 1'b0;
		end else begin
			wr_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_empty) begin
						cmd_q            <= q_data;
						v_q              <= q_data.top[YW-1:0];
						h_q              <= q_data.left[XW-1:0];
						base_q           <= AW'(AW'(q_data.top[YW-1:0]) * ROW_STEP);
						res_q.status     <= q_data.status;
						res_q.read_value <= '0;
						unique case (q_data.kind)
							prde_pkg::CMD_DRAW: state_q <= ST_SCAN;
							prde_pkg::CMD_READ: state_q <= ST_READ;
							default:            state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					wr_s1   <= (cmd_q.op != prde_pkg::OP_FRAME) || on_edge;
					inv_s1  <= (cmd_q.op == prde_pkg::OP_INV);
					addr_s1 <= rd_addr;
					data_s1 <= ((cmd_q.op == prde_pkg::OP_FRAME) || pat_bit) ?
					           fore_pix : back_pix;
					if (h_last) begin
						h_q <= cmd_q.left[XW-1:0];
						if (v_last) begin
							state_q <= ST_DRAIN;
						end else begin
							v_q    <= v_next;
							base_q <= base_q + ROW_STEP;
						end
					end else begin
						h_q <= h_next;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_READ:  state_q <= ST_RWAIT;
				ST_RWAIT: begin
					res_q.read_value <= rd_data_q;
					state_q          <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
